// File: hdl/nine_patch_slicer_assert.svh
// Assertion macros shared by the nine-patch slicer RTL.
`ifndef NINE_PATCH_SLICER_ASSERT_SVH
`define NINE_PATCH_SLICER_ASSERT_SVH
`ifndef ASSERT_OFF
`define NPS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define NPS_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define NPS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define NPS_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// File: hdl/nps_pkg.sv
// Shared types and constants of the nine-patch slicer.
package nps_pkg;

  localparam int COORD_BITS = 20;
  localparam int IMAGE_BITS = COORD_BITS - 2;
  localparam int EDGE_BITS  = COORD_BITS + 1;
  localparam int WIDE_BITS  = COORD_BITS + 3;
  localparam int STEP_BITS  = $clog2(COORD_BITS);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [IMAGE_BITS-1:0] image_t;

  typedef struct packed {
    coord_t s0;
    coord_t s1;
    coord_t d0;
    coord_t d1;
  } slice_t;

  typedef enum logic [2:0] {
    KIND_ONE   = 3'b001,
    KIND_TWO   = 3'b010,
    KIND_THREE = 3'b100
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [1:0]            last_idx;
    logic [COORD_BITS-1:0] dest_mag;
    logic [COORD_BITS-1:0] e0_mag;
    logic [EDGE_BITS-1:0]  edges_mag;
  } ax_info_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hdl/nps_muldiv.sv
// Shared multiply and restoring divide unit: quotient = floor(a * b / divisor).
module nps_muldiv (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [nps_pkg::COORD_BITS-1:0]      mul_a,
  input  logic [nps_pkg::COORD_BITS-1:0]      mul_b,
  input  logic [nps_pkg::EDGE_BITS-1:0]       divisor,
  output logic [nps_pkg::COORD_BITS-1:0]      quotient,
  output nps_pkg::div_stat_t                  stat
);

  localparam int CB = nps_pkg::COORD_BITS;
  localparam int EB = nps_pkg::EDGE_BITS;
  localparam int SB = nps_pkg::STEP_BITS;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_MUL  = 3'b010,
    PH_STEP = 3'b100
  } phase_t;

  phase_t                phase;
  logic [SB-1:0]         step;
  logic                  done;
  logic [CB-1:0]         op_a;
  logic [CB-1:0]         op_b;
  logic [EB-1:0]         dvs;
  logic [EB-1:0]         rem;
  logic [CB-1:0]         qsh;
  logic [2*CB-1:0]       product;
  logic [EB:0]           trial;
  logic                  fits;

  assign product = op_a * op_b;
  assign trial   = {rem, qsh[CB-1]};
  assign fits    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_MUL;
          end
        end
        PH_MUL: begin
          phase <= PH_STEP;
          step  <= '0;
        end
        PH_STEP: begin
          if (step == SB'(CB - 1)) begin
            phase <= PH_IDLE;
            done  <= 1'b1;
          end else begin
            step <= step + 1'b1;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  // The quotient is known to fit in CB bits, so the high half of the
  // product is already below the divisor and seeds the remainder.
  always_ff @(posedge clk) begin
    if (phase == PH_IDLE && start) begin
      op_a <= mul_a;
      op_b <= mul_b;
      dvs  <= divisor;
    end
    if (phase == PH_MUL) begin
      rem <= EB'(product[2*CB-1:CB]);
      qsh <= product[CB-1:0];
    end else if (phase == PH_STEP) begin
      if (fits) begin
        rem <= EB'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[EB-1:0];
      end
      qsh <= {qsh[CB-2:0], fits};
    end
  end

  assign quotient  = qsh;
  assign stat.busy = (phase != PH_IDLE);
  assign stat.done = done;

  `include "nine_patch_slicer_assert.svh"

  `NPS_ASSERT_NEVER(a_start_while_busy, clk, rst, start && phase != PH_IDLE)
  `NPS_ASSERT_IMPLIES(a_done_after_step, clk, rst, done, $past(phase) == PH_STEP)

endmodule

// File: hdl/nps_axis.sv
// Slicing of one axis: picks the slicing case and forms the slice bounds.
module nps_axis (
  input  nps_pkg::image_t                     size,
  input  nps_pkg::coord_t                     c0,
  input  nps_pkg::coord_t                     c1,
  input  nps_pkg::coord_t                     d0,
  input  nps_pkg::coord_t                     d1,
  input  logic [nps_pkg::COORD_BITS-1:0]      quotient,
  output nps_pkg::ax_info_t                   info,
  output nps_pkg::slice_t                     slices [3]
);

  localparam int CB = nps_pkg::COORD_BITS;
  localparam int EB = nps_pkg::EDGE_BITS;
  localparam int WB = nps_pkg::WIDE_BITS;

  logic signed [WB-1:0] size_w;
  logic signed [WB-1:0] c0_w;
  logic signed [WB-1:0] c1_w;
  logic signed [WB-1:0] d0_w;
  logic signed [WB-1:0] d1_w;
  logic signed [WB-1:0] dest_w;
  logic signed [WB-1:0] e1_w;
  logic signed [WB-1:0] edges_w;
  logic signed [WB-1:0] mag_w;
  logic                 e0_neg;
  logic [CB-1:0]        size_c;
  logic [CB-1:0]        m_split;
  logic [CB-1:0]        m0;
  logic [CB-1:0]        m1;

  assign size_w  = WB'(size);
  assign c0_w    = WB'(c0);
  assign c1_w    = WB'(c1);
  assign d0_w    = WB'(d0);
  assign d1_w    = WB'(d1);
  assign dest_w  = d1_w - d0_w;
  assign e1_w    = size_w - c1_w;
  assign edges_w = c0_w + e1_w;
  assign e0_neg  = c0_w[WB-1];
  assign mag_w   = e0_neg ? -c0_w : c0_w;

  assign size_c  = CB'(size);
  assign m_split = e0_neg ? (d0 - quotient) : (d0 + quotient);
  assign m0      = d0 + c0;
  assign m1      = d1 - e1_w[CB-1:0];

  always_comb begin
    info.dest_mag  = dest_w[CB-1:0];
    info.e0_mag    = mag_w[CB-1:0];
    info.edges_mag = edges_w[EB-1:0];
    priority if (size_w == dest_w) begin
      info.kind     = nps_pkg::KIND_ONE;
      info.last_idx = 2'd0;
    end else if (edges_w >= dest_w) begin
      info.kind     = nps_pkg::KIND_TWO;
      info.last_idx = 2'd1;
    end else begin
      info.kind     = nps_pkg::KIND_THREE;
      info.last_idx = 2'd2;
    end
  end

  always_comb begin
    slices[0] = '{s0: '0, s1: c0, d0: d0, d1: m0};
    slices[1] = '{s0: c0, s1: c1, d0: m0, d1: m1};
    slices[2] = '{s0: c1, s1: size_c, d0: m1, d1: d1};
    unique case (info.kind)
      nps_pkg::KIND_ONE: begin
        slices[0] = '{s0: '0, s1: size_c, d0: d0, d1: d1};
      end
      nps_pkg::KIND_TWO: begin
        slices[0] = '{s0: '0, s1: c0, d0: d0, d1: m_split};
        slices[1] = '{s0: c1, s1: size_c, d0: m_split, d1: d1};
      end
      nps_pkg::KIND_THREE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/nine_patch_slicer.sv
// Nine-patch slicer: turns one draw request into up to nine rectangle pairs.
//
// Input channel (in_valid/in_ready) takes one request: image size, center
// rectangle and destination rectangle, all in 1/16 pixel fixed point.
// Output channel (out_valid/out_ready) gives the source/destination pairs,
// rows outer and columns inner, with last_piece high on the final pair.
// A request whose destination has no positive width or height gives none.
// The request is worked through one axis at a time by a single multiplier
// and a one-bit-per-cycle divider shared by both axes. An axis that needs
// a proportional split goes through setup, multiply, 20 divide steps and
// writeback; other axes are written back at setup. Then one pair is sent
// per cycle while the receiver does not stall. in_ready is high only
// between requests.
// The output sits in a register: when the receiver stalls, the pair holds
// and the slicer waits, and out_valid stays high until the pair is taken.
// Reset (rst, synchronous) returns to the idle state with no output valid.
module nine_patch_slicer (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  nps_pkg::image_t         image_width,
  input  nps_pkg::image_t         image_height,
  input  nps_pkg::coord_t         center_left,
  input  nps_pkg::coord_t         center_top,
  input  nps_pkg::coord_t         center_right,
  input  nps_pkg::coord_t         center_bottom,
  input  nps_pkg::coord_t         dest_left,
  input  nps_pkg::coord_t         dest_top,
  input  nps_pkg::coord_t         dest_right,
  input  nps_pkg::coord_t         dest_bottom,
  output logic                    out_valid,
  input  logic                    out_ready,
  output nps_pkg::coord_t         src_x0,
  output nps_pkg::coord_t         src_y0,
  output nps_pkg::coord_t         src_x1,
  output nps_pkg::coord_t         src_y1,
  output nps_pkg::coord_t         dst_x0,
  output nps_pkg::coord_t         dst_y0,
  output nps_pkg::coord_t         dst_x1,
  output nps_pkg::coord_t         dst_y1,
  output logic                    last_piece
);

  localparam int CB = nps_pkg::COORD_BITS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SETUP = 4'b0010,
    S_DIV   = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t               state;
  logic                 ax;
  nps_pkg::image_t      iw, ih;
  nps_pkg::coord_t      cl, ct, cr, cb, dl, dt, dr, db;
  nps_pkg::slice_t      h_sl [3];
  nps_pkg::slice_t      v_sl [3];
  logic [1:0]           h_last, v_last;
  logic [1:0]           col, row;

  nps_pkg::image_t      ax_size;
  nps_pkg::coord_t      ax_c0, ax_c1, ax_d0, ax_d1;
  nps_pkg::ax_info_t    ax_info;
  nps_pkg::slice_t      ax_sl [3];
  logic [CB-1:0]        quotient;
  nps_pkg::div_stat_t   div_stat;
  logic                 div_start;
  logic                 ax_write;
  logic                 empty_req;
  logic                 out_free;
  logic                 pair_last;

  assign ax_size = ax ? ih : iw;
  assign ax_c0   = ax ? ct : cl;
  assign ax_c1   = ax ? cb : cr;
  assign ax_d0   = ax ? dt : dl;
  assign ax_d1   = ax ? db : dr;

  nps_axis u_axis (
    .size     (ax_size),
    .c0       (ax_c0),
    .c1       (ax_c1),
    .d0       (ax_d0),
    .d1       (ax_d1),
    .quotient (quotient),
    .info     (ax_info),
    .slices   (ax_sl)
  );

  nps_muldiv u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .mul_a    (ax_info.dest_mag),
    .mul_b    (ax_info.e0_mag),
    .divisor  (ax_info.edges_mag),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign in_ready  = (state == S_IDLE);
  assign empty_req = (dest_right <= dest_left) || (dest_bottom <= dest_top);
  assign div_start = (state == S_SETUP) && (ax_info.kind == nps_pkg::KIND_TWO);
  assign ax_write  = ((state == S_SETUP) && (ax_info.kind != nps_pkg::KIND_TWO)) ||
                     ((state == S_DIV) && div_stat.done);
  assign out_free  = !out_valid || out_ready;
  assign pair_last = (col == h_last) && (row == v_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ax        <= 1'b0;
      col       <= 2'd0;
      row       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !empty_req) begin
            state <= S_SETUP;
            ax    <= 1'b0;
          end
        end
        S_SETUP, S_DIV: begin
          if (div_start) begin
            state <= S_DIV;
          end else if (ax_write) begin
            if (!ax) begin
              ax    <= 1'b1;
              state <= S_SETUP;
            end else begin
              state <= S_EMIT;
              col   <= 2'd0;
              row   <= 2'd0;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (col == h_last) begin
              col <= 2'd0;
              if (row == v_last) begin
                state <= S_IDLE;
              end else begin
                row <= row + 1'b1;
              end
            end else begin
              col <= col + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      iw <= image_width;
      ih <= image_height;
      cl <= center_left;
      ct <= center_top;
      cr <= center_right;
      cb <= center_bottom;
      dl <= dest_left;
      dt <= dest_top;
      dr <= dest_right;
      db <= dest_bottom;
    end
    if (ax_write) begin
      if (ax) begin
        v_sl   <= ax_sl;
        v_last <= ax_info.last_idx;
      end else begin
        h_sl   <= ax_sl;
        h_last <= ax_info.last_idx;
      end
    end
    if (state == S_EMIT && out_free) begin
      src_x0     <= h_sl[col].s0;
      src_x1     <= h_sl[col].s1;
      dst_x0     <= h_sl[col].d0;
      dst_x1     <= h_sl[col].d1;
      src_y0     <= v_sl[row].s0;
      src_y1     <= v_sl[row].s1;
      dst_y0     <= v_sl[row].d0;
      dst_y1     <= v_sl[row].d1;
      last_piece <= pair_last;
    end
  end

  `include "nine_patch_slicer_assert.svh"

  `NPS_ASSERT_NEVER(a_div_overlap, clk, rst, div_start && div_stat.busy)
  `NPS_ASSERT_IMPLIES(a_div_alive, clk, rst, state == S_DIV, div_stat.busy || div_stat.done)
  `NPS_ASSERT_IMPLIES(a_emit_bounds, clk, rst, state == S_EMIT, col <= h_last && row <= v_last)
  `NPS_ASSERT_IMPLIES(a_out_hold, clk, rst, $past(out_valid && !out_ready && !rst), out_valid)

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the nine-patch slicer: random and directed draw requests.
`timescale 1ns / 100ps

module testbench;
  typedef nps_pkg::image_t image_t;
  typedef nps_pkg::coord_t coord_t;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_REQS  = 300;
  localparam int PHASE_REQS   = 40;
  localparam int HOLDOFF_AT   = 150;
  localparam int HOLDOFF_LEN  = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int LIMIT_CYCLES = 600000;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    image_t image_width;
    image_t image_height;
    coord_t center_left;
    coord_t center_top;
    coord_t center_right;
    coord_t center_bottom;
    coord_t dest_left;
    coord_t dest_top;
    coord_t dest_right;
    coord_t dest_bottom;
  } draw_req_t;

  typedef struct {
    coord_t src_x0;
    coord_t src_y0;
    coord_t src_x1;
    coord_t src_y1;
    coord_t dst_x0;
    coord_t dst_y0;
    coord_t dst_x1;
    coord_t dst_y1;
    logic   last_piece;
  } piece_t;

  // One slice of one axis, kept at full precision until it is packed.
  typedef struct {
    longint src_lo;
    longint src_hi;
    longint dst_lo;
    longint dst_hi;
  } span_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  logic      out_valid;
  logic      out_ready = 1'b0;
  draw_req_t offered_req = '{default: '0};
  coord_t    src_x0, src_y0, src_x1, src_y1;
  coord_t    dst_x0, dst_y0, dst_x1, dst_y1;
  logic      last_piece;

  draw_req_t  pending_reqs[$];
  piece_t     expected_pieces[$];
  logic       req_taken = 1'b0;
  int         accepted_reqs = 0;
  int         error_count = 0;
  int         holdoff_cycles = 0;
  logic       holdoff_done = 1'b0;
  idle_mode_e idle_mode;
  int         send_idle_pct;
  int         recv_stall_pct;

  nine_patch_slicer u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .image_width  (offered_req.image_width),
    .image_height (offered_req.image_height),
    .center_left  (offered_req.center_left),
    .center_top   (offered_req.center_top),
    .center_right (offered_req.center_right),
    .center_bottom(offered_req.center_bottom),
    .dest_left    (offered_req.dest_left),
    .dest_top     (offered_req.dest_top),
    .dest_right   (offered_req.dest_right),
    .dest_bottom  (offered_req.dest_bottom),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .src_x0       (src_x0),
    .src_y0       (src_y0),
    .src_x1       (src_x1),
    .src_y1       (src_y1),
    .dst_x0       (dst_x0),
    .dst_y0       (dst_y0),
    .dst_x1       (dst_x1),
    .dst_y1       (dst_y1),
    .last_piece   (last_piece)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  function automatic draw_req_t make_req(input longint iw, ih, cl, ct, cr, cb,
                                         dl, dt, dr, db);
    draw_req_t r;
    r.image_width   = image_t'(iw);
    r.image_height  = image_t'(ih);
    r.center_left   = coord_t'(cl);
    r.center_top    = coord_t'(ct);
    r.center_right  = coord_t'(cr);
    r.center_bottom = coord_t'(cb);
    r.dest_left     = coord_t'(dl);
    r.dest_top      = coord_t'(dt);
    r.dest_right    = coord_t'(dr);
    r.dest_bottom   = coord_t'(db);
    return r;
  endfunction

  // Cuts one axis into one, two or three slices; returns the slice count.
  function automatic int cut_axis(input longint size, c0, c1, d0, d1,
                                  output span_t spans[3]);
    longint dest, far_edge, edges, mid;
    dest     = d1 - d0;
    far_edge = size - c1;
    edges    = c0 + far_edge;
    if (size == dest) begin
      spans[0] = '{0, size, d0, d1};
      return 1;
    end
    if (edges >= dest) begin
      // Signed division truncates toward zero, as the split requires.
      mid = d0 + (dest * c0) / edges;
      spans[0] = '{0, c0, d0, mid};
      spans[1] = '{c1, size, mid, d1};
      return 2;
    end
    spans[0] = '{0, c0, d0, d0 + c0};
    spans[1] = '{c0, c1, d0 + c0, d1 - far_edge};
    spans[2] = '{c1, size, d1 - far_edge, d1};
    return 3;
  endfunction

  task automatic slice_request(input draw_req_t r);
    span_t  cols[3];
    span_t  rows[3];
    int     ncol;
    int     nrow;
    piece_t p;
    if (r.dest_right <= r.dest_left || r.dest_bottom <= r.dest_top) return;
    ncol = cut_axis(longint'(r.image_width), longint'(r.center_left),
                    longint'(r.center_right), longint'(r.dest_left),
                    longint'(r.dest_right), cols);
    nrow = cut_axis(longint'(r.image_height), longint'(r.center_top),
                    longint'(r.center_bottom), longint'(r.dest_top),
                    longint'(r.dest_bottom), rows);
    for (int y = 0; y < nrow; y++) begin
      for (int x = 0; x < ncol; x++) begin
        p.src_x0     = coord_t'(cols[x].src_lo);
        p.src_y0     = coord_t'(rows[y].src_lo);
        p.src_x1     = coord_t'(cols[x].src_hi);
        p.src_y1     = coord_t'(rows[y].src_hi);
        p.dst_x0     = coord_t'(cols[x].dst_lo);
        p.dst_y0     = coord_t'(rows[y].dst_lo);
        p.dst_x1     = coord_t'(cols[x].dst_hi);
        p.dst_y1     = coord_t'(rows[y].dst_hi);
        p.last_piece = (y == nrow - 1) && (x == ncol - 1);
        expected_pieces.push_back(p);
      end
    end
  endtask

  // Mostly well-formed axes aimed at each slicing case, with some raw noise.
  task automatic pick_axis(output longint size, c0, c1, d0, d1);
    longint dest;
    longint edges;
    int     mode;
    coord_t raw;
    mode = $urandom_range(0, 9);
    if (mode == 9) begin
      size = $urandom_range(0, 262143);
      raw = coord_t'($urandom);
      c0 = longint'(raw);
      raw = coord_t'($urandom);
      c1 = longint'(raw);
      raw = coord_t'($urandom);
      d0 = longint'(raw);
      raw = coord_t'($urandom);
      d1 = longint'(raw);
      return;
    end
    size = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 262143) : $urandom_range(1, 2047);
    c0 = $urandom_range(0, int'(size));
    c1 = c0 + $urandom_range(0, int'(size - c0));
    edges = c0 + size - c1;
    if (mode <= 2) begin
      dest = size;
    end else if (mode <= 5) begin
      dest = (edges == 0) ? 1 : $urandom_range(1, int'(edges));
    end else begin
      dest = edges + $urandom_range(1, 4095);
    end
    d0 = longint'($urandom_range(0, int'(1048575 - dest))) - 524288;
    d1 = d0 + dest;
  endtask

  always_comb begin
    idle_mode = idle_mode_e'((accepted_reqs / PHASE_REQS) % 4);
    case (idle_mode)
      IDLE_SENDER: begin
        send_idle_pct  = 62;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 62;
      end
      IDLE_BOTH: begin
        send_idle_pct  = 38;
        recv_stall_pct = 38;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  end

  // Request driver: a new request is offered only once the last one is taken.
  always @(negedge clk) begin : drive_requests
    draw_req_t next_req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        offered_req <= next_req;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the slicer backs up.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (holdoff_cycles != 0) begin
      holdoff_cycles <= holdoff_cycles - 1;
      out_ready <= 1'b0;
    end else if (!holdoff_done && accepted_reqs >= HOLDOFF_AT) begin
      holdoff_done <= 1'b1;
      holdoff_cycles <= HOLDOFF_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watch_ports
    piece_t got;
    piece_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        slice_request(offered_req);
        accepted_reqs++;
      end
      if (out_valid && out_ready) begin
        got = '{src_x0, src_y0, src_x1, src_y1, dst_x0, dst_y0, dst_x1, dst_y1, last_piece};
        if (expected_pieces.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected piece: src %0d,%0d..%0d,%0d dst %0d,%0d..%0d,%0d last %0b",
                     got.src_x0, got.src_y0, got.src_x1, got.src_y1,
                     got.dst_x0, got.dst_y0, got.dst_x1, got.dst_y1, got.last_piece);
        end else begin
          want = expected_pieces.pop_front();
          if (got.src_x0 !== want.src_x0 || got.src_y0 !== want.src_y0 ||
              got.src_x1 !== want.src_x1 || got.src_y1 !== want.src_y1 ||
              got.dst_x0 !== want.dst_x0 || got.dst_y0 !== want.dst_y0 ||
              got.dst_x1 !== want.dst_x1 || got.dst_y1 !== want.dst_y1 ||
              got.last_piece !== want.last_piece) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("piece mismatch: expected src %0d,%0d..%0d,%0d dst %0d,%0d..%0d,%0d last %0b",
                       want.src_x0, want.src_y0, want.src_x1, want.src_y1,
                       want.dst_x0, want.dst_y0, want.dst_x1, want.dst_y1, want.last_piece);
              $display("                got src %0d,%0d..%0d,%0d dst %0d,%0d..%0d,%0d last %0b",
                       got.src_x0, got.src_y0, got.src_x1, got.src_y1,
                       got.dst_x0, got.dst_y0, got.dst_x1, got.dst_y1, got.last_piece);
            end
          end
        end
      end
    end
  end

  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin : stimulus
    longint sx, sy, cx0, cy0, cx1, cy1, dx0, dy0, dx1, dy1;
    int     drawn;
    // Empty destinations, one per axis, then one with reversed extremes.
    pending_reqs.push_back(make_req(160, 160, 32, 32, 128, 128, 100, 100, 100, 300));
    pending_reqs.push_back(make_req(160, 160, 32, 32, 128, 128, 0, 500, 200, 400));
    pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 524287, 0, -524288, 10));
    // Each slice count on both axes, and each pair of different counts once.
    pending_reqs.push_back(make_req(160, 96, 32, 16, 128, 80, -80, -40, 80, 56));
    pending_reqs.push_back(make_req(320, 320, 100, 100, 220, 220, 0, 0, 150, 150));
    pending_reqs.push_back(make_req(320, 320, 64, 64, 256, 256, 16, 16, 1016, 1016));
    pending_reqs.push_back(make_req(160, 320, 32, 100, 128, 220, 0, 0, 160, 150));
    pending_reqs.push_back(make_req(320, 320, 100, 64, 220, 256, 0, 0, 150, 1000));
    pending_reqs.push_back(make_req(320, 96, 64, 16, 256, 80, 0, 0, 1000, 96));
    // Reversed center rectangles.
    pending_reqs.push_back(make_req(320, 320, 250, 250, 70, 70, 0, 0, 500, 500));
    pending_reqs.push_back(make_req(320, 320, 250, 40, 70, 10, 0, 0, 300, 1000));
    // Centers outside the image, including a split with a negative left edge.
    pending_reqs.push_back(make_req(100, 100, -50, -50, -300, -300, 0, 0, 200, 200));
    pending_reqs.push_back(make_req(100, 100, 20, 20, 400, 400, 0, 0, 500, 500));
    pending_reqs.push_back(make_req(0, 0, -100, -100, -500, -500, 0, 0, 7, 7));
    // Field extremes; several of these wrap the output coordinates.
    pending_reqs.push_back(make_req(262143, 262143, -524288, -524288, 524287, 524287,
                                    -524288, -524288, 524287, 524287));
    pending_reqs.push_back(make_req(262143, 0, 524287, 524287, -524288, -524288,
                                    0, 0, 1, 1));
    pending_reqs.push_back(make_req(262143, 262143, 524287, 524287, -524288, -524288,
                                    -524288, -524288, 524287, 524287));
    pending_reqs.push_back(make_req(1, 1, 0, 0, 1, 1, 524286, 524286, 524287, 524287));
    pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, -524288, -524288, 524287, 524287));

    drawn = 0;
    while (drawn < RANDOM_REQS) begin
      pick_axis(sx, cx0, cx1, dx0, dx1);
      pick_axis(sy, cy0, cy1, dy0, dy1);
      pending_reqs.push_back(make_req(sx, sy, cx0, cy0, cx1, cy1, dx0, dy0, dx1, dy1));
      if (coord_t'(dx1) > coord_t'(dx0) && coord_t'(dy1) > coord_t'(dy0)) drawn++;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_pieces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_pieces.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: nine_patch_slicer.f
+incdir+hdl
hdl/nps_pkg.sv
hdl/nps_muldiv.sv
hdl/nps_axis.sv
hdl/nine_patch_slicer.sv
tb/testbench.sv
